// ----- rtl/tape_machine_instruction_exec_top_defines.svh -----
// assertion macros for the tape machine executor
// used by tape_machine_instruction_exec_top; no other dependencies
`ifndef TAPE_MACHINE_INSTRUCTION_EXEC_TOP_DEFINES_SVH
`define TAPE_MACHINE_INSTRUCTION_EXEC_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define TMIE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define TMIE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/tmie_pkg.sv -----
// shared constants, command codes and structs for the tape machine executor
// no dependencies
package tmie_pkg;

   localparam int WORD_W        = 28;
   localparam int CMD_W         = 4;
   localparam int BYTE_W        = 8;
   localparam int TAPE_DEPTH_DEF = 4096;
   localparam int REQ_DATA_W    = 40;
   localparam int RSP_DATA_W    = 96;

   localparam logic [CMD_W-1:0] CMD_ADD   = 4'd0;
   localparam logic [CMD_W-1:0] CMD_SUB   = 4'd1;
   localparam logic [CMD_W-1:0] CMD_RIGHT = 4'd2;
   localparam logic [CMD_W-1:0] CMD_LEFT  = 4'd3;
   localparam logic [CMD_W-1:0] CMD_OUT   = 4'd4;
   localparam logic [CMD_W-1:0] CMD_IN    = 4'd5;
   localparam logic [CMD_W-1:0] CMD_JZ    = 4'd6;
   localparam logic [CMD_W-1:0] CMD_JNZ   = 4'd7;
   localparam logic [CMD_W-1:0] CMD_HALT  = 4'd15;

   localparam logic CSR_OUT_EN = 1'b0;
   localparam logic CSR_IN_EN  = 1'b1;

   // instruction handed from the issue side to the execute stage
   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [WORD_W-1:0] opnd;
      logic [BYTE_W-1:0] in_byte;
      logic              fault;
      logic              ignore;
   } issue_type;

   // result item as it sits in the output register
   typedef struct packed {
      logic              tape_fault;
      logic              halted;
      logic [WORD_W-1:0] in_count;
      logic [WORD_W-1:0] out_count;
      logic [BYTE_W-1:0] out_byte;
      logic [WORD_W-1:0] next_pc;
   } result_type;

endpackage

// ----- rtl/tmie_tape_ram.sv -----
// tape cell memory: one write port, one read port with registered data
// depends on tmie_pkg
module tmie_tape_ram #(
   parameter int TAPE_DEPTH = tmie_pkg::TAPE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [$clog2(TAPE_DEPTH)-1:0]     wr_addr,
   input  logic [tmie_pkg::BYTE_W-1:0]       wr_data,
   input  logic                              rd_en,
   input  logic [$clog2(TAPE_DEPTH)-1:0]     rd_addr,
   output logic [tmie_pkg::BYTE_W-1:0]       rd_data
);
   import tmie_pkg::*;

   logic [BYTE_W-1:0] mem [TAPE_DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/tmie_exec.sv -----
// execute stage: cell update, jumps, program counter and result register
// depends on tmie_pkg
module tmie_exec #(
   parameter int TAPE_DEPTH = tmie_pkg::TAPE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              issue_valid,
   input  tmie_pkg::issue_type               issue,
   input  logic [$clog2(TAPE_DEPTH)-1:0]     issue_addr,
   input  logic [tmie_pkg::BYTE_W-1:0]       rd_data,
   input  logic                              out_en,
   input  logic                              in_en,
   output logic                              stage_free,
   output logic                              wr_en,
   output logic [$clog2(TAPE_DEPTH)-1:0]     wr_addr,
   output logic [tmie_pkg::BYTE_W-1:0]       wr_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output tmie_pkg::result_type              rsp_result
);
   import tmie_pkg::*;

   localparam int ADDR_W = $clog2(TAPE_DEPTH);

   logic              s1_valid_ff, s1_valid_in;
   issue_type         s1_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic              fwd_hit_ff;
   logic [BYTE_W-1:0] fwd_data_ff;
   logic [WORD_W-1:0] pc_ff, pc_in;
   logic              out_valid_ff, out_valid_in;
   result_type        out_ff, res;
   logic              s1_go;
   logic [BYTE_W-1:0] cur_byte;
   logic              we;
   logic [BYTE_W-1:0] wdata;

   assign s1_go      = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign stage_free = !s1_valid_ff || s1_go;
   // a write on the same edge as this item's read is not seen by the ram
   assign cur_byte = fwd_hit_ff ? fwd_data_ff : rd_data;

   always_comb begin
      res            = '0;
      res.next_pc    = pc_ff + WORD_W'(1);
      res.tape_fault = s1_ff.fault;
      we             = 1'b0;
      wdata          = cur_byte;
      if (s1_ff.ignore) begin
         res.next_pc = pc_ff;
         res.halted  = 1'b1;
      end else begin
         case (s1_ff.cmd)
            CMD_ADD: begin
               we    = 1'b1;
               wdata = cur_byte + s1_ff.opnd[BYTE_W-1:0];
            end
            CMD_SUB: begin
               we    = 1'b1;
               wdata = cur_byte - s1_ff.opnd[BYTE_W-1:0];
            end
            CMD_OUT: begin
               if (out_en && (s1_ff.opnd != '0)) begin
                  res.out_byte  = cur_byte;
                  res.out_count = s1_ff.opnd;
               end
            end
            CMD_IN: begin
               if (in_en && (s1_ff.opnd != '0)) begin
                  we           = 1'b1;
                  wdata        = s1_ff.in_byte;
                  res.in_count = s1_ff.opnd;
               end
            end
            CMD_JZ: begin
               if (cur_byte == '0) begin
                  res.next_pc = s1_ff.opnd;
               end
            end
            CMD_JNZ: begin
               if (cur_byte != '0) begin
                  res.next_pc = s1_ff.opnd;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign wr_en   = s1_go && we;
   assign wr_addr = s1_addr_ff;
   assign wr_data = wdata;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (issue_valid) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (s1_go) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      pc_in = s1_go ? res.next_pc : pc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pc_ff        <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         pc_ff        <= pc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue_valid) begin
         s1_ff       <= issue;
         s1_addr_ff  <= issue_addr;
         fwd_hit_ff  <= wr_en && (wr_addr == issue_addr);
         fwd_data_ff <= wdata;
      end
      if (s1_go) begin
         out_ff <= res;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_result = out_ff;

endmodule

// ----- rtl/tape_machine_instruction_exec_top.sv -----
// tape machine executor top: stream ports, head and halt tracking, tape clear sweep;
// uses tmie_pkg, tmie_tape_ram, tmie_exec and the defines header
// result path: exec stage register, then output register; rsp_tready low holds it
// throughput: one instruction per cycle unless the output stalls or the sweep runs;
// write-back forwarded to the next tape read; reset: synchronous; head to mid-tape,
// pc, halt flag, enables cleared; then a sweep zeroes the tape with req_tready low
module tape_machine_instruction_exec_top #(
   parameter int TAPE_DEPTH = tmie_pkg::TAPE_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // command[3:0], operand[31:4], in_byte[39:32]
   input  logic [tmie_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // next_pc[27:0], out_byte[35:28], out_count[63:36], in_count[91:64],
   // halted[92], tape_fault[93], zero[95:94]
   output logic [tmie_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_we,
   input  logic                               csr_index,
   input  logic                               csr_wdata
);
   import tmie_pkg::*;

   `include "tape_machine_instruction_exec_top_defines.svh"

   localparam int ADDR_W = $clog2(TAPE_DEPTH);
   localparam int SUM_W  = WORD_W + 1;

   logic              out_en_ff, in_en_ff;
   logic [ADDR_W-1:0] head_ff, head_in;
   logic              stop_ff, stop_in;
   logic              clr_ff, clr_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   logic [CMD_W-1:0]  req_cmd;
   logic [WORD_W-1:0] req_opnd;
   logic [BYTE_W-1:0] req_byte;
   logic              req_xfer;
   logic [SUM_W-1:0]  right_sum;
   issue_type         issue;
   logic              stage_free;
   logic              ex_wr_en;
   logic [ADDR_W-1:0] ex_wr_addr;
   logic [BYTE_W-1:0] ex_wr_data;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [BYTE_W-1:0] ram_wdata;
   logic [BYTE_W-1:0] ram_rdata;
   result_type        result;

   assign req_cmd  = req_tdata[CMD_W-1:0];
   assign req_opnd = req_tdata[CMD_W+WORD_W-1:CMD_W];
   assign req_byte = req_tdata[CMD_W+WORD_W+BYTE_W-1:CMD_W+WORD_W];

   assign req_tready = !clr_ff && stage_free;
   assign req_xfer   = req_tvalid && req_tready;

   assign right_sum = SUM_W'(head_ff) + SUM_W'(req_opnd);

   // head moves and halt are settled at transfer, without the cell value
   always_comb begin
      issue.cmd     = req_cmd;
      issue.opnd    = req_opnd;
      issue.in_byte = req_byte;
      issue.fault   = 1'b0;
      issue.ignore  = stop_ff || (req_cmd == CMD_HALT);
      head_in       = head_ff;
      stop_in       = stop_ff;
      if (req_xfer && !stop_ff) begin
         case (req_cmd)
            CMD_RIGHT: begin
               if (right_sum >= SUM_W'(TAPE_DEPTH)) begin
                  issue.fault = 1'b1;
               end else begin
                  head_in = right_sum[ADDR_W-1:0];
               end
            end
            CMD_LEFT: begin
               if (req_opnd > WORD_W'(head_ff)) begin
                  issue.fault = 1'b1;
               end else begin
                  head_in = head_ff - req_opnd[ADDR_W-1:0];
               end
            end
            CMD_HALT: begin
               stop_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == ADDR_W'(TAPE_DEPTH - 1)) begin
            clr_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= ADDR_W'(TAPE_DEPTH / 2);
         stop_ff     <= 1'b0;
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
         out_en_ff   <= 1'b0;
         in_en_ff    <= 1'b0;
      end else begin
         head_ff     <= head_in;
         stop_ff     <= stop_in;
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
         if (csr_we && (csr_index == CSR_OUT_EN)) begin
            out_en_ff <= csr_wdata;
         end
         if (csr_we && (csr_index == CSR_IN_EN)) begin
            in_en_ff <= csr_wdata;
         end
      end
   end

   assign ram_we    = clr_ff || ex_wr_en;
   assign ram_waddr = clr_ff ? clr_addr_ff : ex_wr_addr;
   assign ram_wdata = clr_ff ? '0 : ex_wr_data;

   tmie_tape_ram #(
      .TAPE_DEPTH (TAPE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (req_xfer),
      .rd_addr (head_ff),
      .rd_data (ram_rdata)
   );

   tmie_exec #(
      .TAPE_DEPTH (TAPE_DEPTH)
   ) u_exec (
      .clock       (clock),
      .reset       (reset),
      .issue_valid (req_xfer),
      .issue       (issue),
      .issue_addr  (head_ff),
      .rd_data     (ram_rdata),
      .out_en      (out_en_ff),
      .in_en       (in_en_ff),
      .stage_free  (stage_free),
      .wr_en       (ex_wr_en),
      .wr_addr     (ex_wr_addr),
      .wr_data     (ex_wr_data),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_result  (result)
   );

   assign rsp_tdata = {2'b00, result};

   `TMIE_ASSERT_SAME(a_no_xfer_in_clear, clock, reset, clr_ff, !req_tready, "transfer in clear")
   `TMIE_ASSERT_NEXT(a_halt_sticks, clock, reset, stop_ff, stop_ff, "halt flag dropped")
   `TMIE_ASSERT_SAME(a_halted_result, clock, reset, rsp_tvalid && result.halted, stop_ff, "halt lost")
   `TMIE_ASSERT_SAME(a_no_exec_write_in_clear, clock, reset, clr_ff, !ex_wr_en, "write in clear")

endmodule

// ----- tb/tb.sv -----
// self-checking bench for tape_machine_instruction_exec_top: drives instruction
// words through the stream ports and checks every result against a scoreboard
// depends on tmie_pkg and the rtl top level
module tb;
   import tmie_pkg::*;

   localparam int TAPE_DEPTH      = TAPE_DEPTH_DEF;
   localparam int STALL_LIMIT     = 20000;
   localparam int ITEMS_PER_PHASE = 330;
   localparam int REPORT_LIMIT    = 10;
   localparam logic [CMD_W-1:0] NOP_FIRST = 4'd8;
   localparam logic [CMD_W-1:0] NOP_LAST  = 4'd14;

   class exec_scoreboard;
      logic [BYTE_W-1:0] cells [TAPE_DEPTH];
      int unsigned       head;
      logic [WORD_W-1:0] pc;
      bit                stopped;
      bit                out_en;
      bit                in_en;
      result_type        pending_results[$];
      int                mismatches;
      int                unexpected;
      int                checked;

      function new();
         foreach (cells[i]) cells[i] = '0;
         head = TAPE_DEPTH / 2;
         pc = '0;
         stopped = 1'b0;
         out_en = 1'b0;
         in_en = 1'b0;
      endfunction

      function void write_reg(logic idx, logic val);
         if (idx == CSR_OUT_EN) out_en = val;
         else in_en = val;
      endfunction

      function void note_request(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] opnd,
                                 logic [BYTE_W-1:0] inb);
         result_type        res;
         logic [WORD_W-1:0] next;
         res = '0;
         next = pc + 1'b1;
         if (stopped) begin
            // after halt nothing moves, pc holds at the halt word
            res.next_pc = pc;
            res.halted = 1'b1;
         end else begin
            case (cmd)
               CMD_ADD: cells[head] = cells[head] + opnd[BYTE_W-1:0];
               CMD_SUB: cells[head] = cells[head] - opnd[BYTE_W-1:0];
               CMD_RIGHT: begin
                  if (longint'(head) + longint'(opnd) >= TAPE_DEPTH) res.tape_fault = 1'b1;
                  else head = head + opnd;
               end
               CMD_LEFT: begin
                  if (opnd > head) res.tape_fault = 1'b1;
                  else head = head - opnd;
               end
               CMD_OUT: begin
                  if (out_en && opnd != 0) begin
                     res.out_byte = cells[head];
                     res.out_count = opnd;
                  end
               end
               CMD_IN: begin
                  if (in_en && opnd != 0) begin
                     cells[head] = inb;
                     res.in_count = opnd;
                  end
               end
               CMD_JZ:  if (cells[head] == 0) next = opnd;
               CMD_JNZ: if (cells[head] != 0) next = opnd;
               CMD_HALT: begin
                  stopped = 1'b1;
                  next = pc;
               end
               default: ;
            endcase
            pc = next;
            res.next_pc = next;
            res.halted = stopped;
         end
         pending_results.push_back(res);
      endfunction

      function void check_result(logic [RSP_DATA_W-1:0] data);
         result_type got;
         result_type want;
         bit         ok;
         got = result_type'(data[$bits(result_type)-1:0]);
         if (pending_results.size() == 0) begin
            unexpected++;
            if (mismatches + unexpected <= REPORT_LIMIT)
               $display("unexpected result transfer: %h", data);
         end else begin
            want = pending_results.pop_front();
            checked++;
            ok = (got.next_pc === want.next_pc) && (got.out_byte === want.out_byte) &&
                 (got.out_count === want.out_count) && (got.in_count === want.in_count) &&
                 (got.halted === want.halted) && (got.tape_fault === want.tape_fault);
            if (!ok) begin
               mismatches++;
               if (mismatches + unexpected <= REPORT_LIMIT) begin
                  $display("mismatch on result %0d: expected pc=%h byte=%h oc=%h ic=%h h=%b f=%b",
                           checked, want.next_pc, want.out_byte, want.out_count,
                           want.in_count, want.halted, want.tape_fault);
                  $display("   actual pc=%h byte=%h oc=%h ic=%h h=%b f=%b",
                           got.next_pc, got.out_byte, got.out_count,
                           got.in_count, got.halted, got.tape_fault);
               end
            end
         end
      endfunction

      function int failures();
         return mismatches + unexpected + pending_results.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_we = 1'b0;
   logic                  csr_index = 1'b0;
   logic                  csr_wdata = 1'b0;

   exec_scoreboard sb = new();
   bit             idle_on = 1'b1;
   int             sent = 0;
   int             stall_count = 0;

   tape_machine_instruction_exec_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= !(idle_on && $urandom_range(0, 99) < 26);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   // counts cycles without any transfer; covers the tape clear sweep after reset
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_count <= 0;
      else stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic send_instr(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] opnd,
                             logic [BYTE_W-1:0] inb);
      while (idle_on && $urandom_range(0, 99) < 26) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {inb, opnd, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(cmd, opnd, inb);
      sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_enables(logic oe, logic ie);
      drain();
      csr_we <= 1'b1;
      csr_index <= CSR_OUT_EN;
      csr_wdata <= oe;
      @(posedge clock);
      sb.write_reg(CSR_OUT_EN, oe);
      csr_index <= CSR_IN_EN;
      csr_wdata <= ie;
      @(posedge clock);
      sb.write_reg(CSR_IN_EN, ie);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_phase(int n);
      logic [CMD_W-1:0]  cmd;
      logic [WORD_W-1:0] opnd;
      logic [BYTE_W-1:0] inb;
      int                pick;
      repeat (n) begin
         pick = $urandom_range(0, 99);
         inb = BYTE_W'($urandom());
         opnd = WORD_W'($urandom());
         if (pick < 14) cmd = CMD_ADD;
         else if (pick < 26) cmd = CMD_SUB;
         else if (pick < 40) cmd = CMD_RIGHT;
         else if (pick < 54) cmd = CMD_LEFT;
         else if (pick < 64) cmd = CMD_OUT;
         else if (pick < 74) cmd = CMD_IN;
         else if (pick < 82) cmd = CMD_JZ;
         else if (pick < 90) cmd = CMD_JNZ;
         else cmd = CMD_W'($urandom_range(NOP_FIRST, NOP_LAST));
         // mostly short moves so the head wanders; now and then a long one that may fault
         if ((cmd == CMD_RIGHT || cmd == CMD_LEFT) && $urandom_range(0, 15) != 0) begin
            if ($urandom_range(0, 6) == 0) opnd = WORD_W'($urandom_range(0, TAPE_DEPTH - 1));
            else opnd = WORD_W'($urandom_range(0, 8));
         end else if (cmd == CMD_OUT || cmd == CMD_IN) begin
            pick = $urandom_range(0, 5);
            if (pick == 0) opnd = '0;
            else if (pick < 4) opnd = WORD_W'($urandom_range(1, 16));
         end else if ((cmd == CMD_ADD || cmd == CMD_SUB) && $urandom_range(0, 1) == 0) begin
            opnd = WORD_W'($urandom_range(0, 255));
         end
         send_instr(cmd, opnd, inb);
      end
   endtask

   initial begin
      bit oe_set [4];
      bit ie_set [4];
      oe_set = '{1'b0, 1'b1, 1'b0, 1'b1};
      ie_set = '{1'b0, 1'b0, 1'b1, 1'b1};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // enables are off after reset
      send_instr(CMD_OUT, 28'd5, 8'h00);
      send_instr(CMD_IN, 28'd5, 8'h77);
      set_enables(1'b1, 1'b1);

      send_instr(CMD_ADD, 28'hFFFFFFF, 8'h00);
      send_instr(CMD_OUT, 28'd0, 8'h00);
      send_instr(CMD_OUT, 28'hFFFFFFF, 8'h00);
      send_instr(CMD_JNZ, 28'hFFFFFFF, 8'h00);
      send_instr(NOP_FIRST, 28'd0, 8'h00);
      send_instr(CMD_SUB, 28'h00000FF, 8'hFF);
      send_instr(CMD_JZ, 28'h5A5A5A5, 8'h00);
      send_instr(CMD_JNZ, 28'd123, 8'h00);
      send_instr(CMD_IN, 28'd0, 8'hFF);
      send_instr(CMD_IN, 28'hFFFFFFF, 8'hA5);
      send_instr(CMD_JZ, 28'd7, 8'h00);
      // walk to both tape ends and try to step past them
      send_instr(CMD_RIGHT, 28'd2047, 8'h00);
      send_instr(CMD_OUT, 28'd3, 8'h00);
      send_instr(CMD_RIGHT, 28'd1, 8'h00);
      send_instr(CMD_RIGHT, 28'hFFFFFFF, 8'h00);
      send_instr(CMD_LEFT, 28'd4095, 8'h00);
      send_instr(CMD_LEFT, 28'd1, 8'h00);
      send_instr(CMD_LEFT, 28'd0, 8'h00);
      send_instr(CMD_RIGHT, 28'd0, 8'h00);
      send_instr(CMD_ADD, 28'h0000100, 8'h00);
      send_instr(NOP_LAST, 28'hFFFFFFF, 8'hFF);
      send_instr(CMD_RIGHT, 28'd2048, 8'h00);

      for (int ph = 0; ph < 4; ph++) begin
         set_enables(oe_set[ph], ie_set[ph]);
         idle_on = (ph != 1);
         random_phase(ITEMS_PER_PHASE);
      end

      // halt, then items that must all be ignored
      send_instr(CMD_HALT, 28'd0, 8'h00);
      send_instr(CMD_ADD, 28'd5, 8'h00);
      send_instr(CMD_RIGHT, 28'd3, 8'h00);
      send_instr(CMD_OUT, 28'd4, 8'h00);
      send_instr(CMD_IN, 28'd9, 8'h3C);
      send_instr(CMD_JZ, 28'd0, 8'h00);
      send_instr(CMD_HALT, 28'hFFFFFFF, 8'hFF);

      drain();
      repeat (6) @(posedge clock);
      $display("ran %0d instructions (%0d results checked) over all four enable settings,",
               sent, sb.checked);
      $display("including tape edge faults, jumps, pc wrap and items after halt");
      if (sb.failures() == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule

// ----- tape_machine_instruction_exec_top.f -----
+incdir+rtl
rtl/tmie_pkg.sv
rtl/tmie_tape_ram.sv
rtl/tmie_exec.sv
rtl/tape_machine_instruction_exec_top.sv
tb/tb.sv
